// ===== src/mandelbrot_escape_iteration_unit_assert.svh =====
// Assertion macros shared by the escape iteration unit
`ifndef MANDELBROT_ESCAPE_ITERATION_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MEIU_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MEIU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/meiu_pkg.sv =====
package meiu_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;

    localparam int IN_W   = 32;
    localparam int ZW     = 37;
    localparam int SPLIT  = 18;
    localparam int HW     = ZW - SPLIT + 1;
    localparam int PPW    = 2 * HW;
    localparam int PW     = 2 * ZW;
    localparam int MW     = PW + 1;
    localparam int CNT_W  = COUNT_WIDTH + 1;
    localparam int ITER_W = 16;
    localparam int MAG_W  = 32;
    localparam int MAG_SHIFT = 2 * FRAC_BITS - 24;
    localparam int LIMIT_EXP = 2 * FRAC_BITS + 2;

    localparam logic [MW-1:0]    MAG_LIMIT = MW'(1) << LIMIT_EXP;
    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'((1 << COUNT_WIDTH) - 1);

    localparam int APB_AW = 3;
    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic [15:0] MAX_ITER_RESET = 16'd255;

    typedef struct packed {
        logic load;
        logic pp_en;
        logic sum_en;
        logic mag_en;
        logic upd;
        logic cnt_inc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mag_ok;
        logic cnt_ok;
    } status_t;

endpackage

// ===== src/meiu_dp.sv =====
module meiu_dp
    import meiu_pkg::*;
(
    input  logic                    clk,
    input  cmd_t                    cmd,
    input  logic signed [IN_W-1:0]  start_re,
    input  logic signed [IN_W-1:0]  start_im,
    input  logic signed [IN_W-1:0]  c_re,
    input  logic signed [IN_W-1:0]  c_im,
    input  logic [15:0]             max_iter,
    output status_t                 status,
    output logic                    inside_res,
    output logic [ITER_W-1:0]       iter_count,
    output logic [MAG_W-1:0]        final_mag_sq
);

    logic signed [ZW-1:0]   z_re_reg, z_im_reg, z_re_next, z_im_next;
    logic signed [IN_W-1:0] c_re_reg, c_im_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic signed [HW-1:0]   re_h, re_l, im_h, im_l;
    logic signed [PPW-1:0]  rr_hh_reg, rr_hl_reg, rr_ll_reg;
    logic signed [PPW-1:0]  ii_hh_reg, ii_hl_reg, ii_ll_reg;
    logic signed [PPW-1:0]  ri_hh_reg, ri_hl_reg, ri_lh_reg, ri_ll_reg;

    logic signed [PW-1:0]   re2_reg, im2_reg, reim_reg;
    logic signed [PW-1:0]   re2_next, im2_next, reim_next;
    logic [MW-1:0]          mag_reg;
    logic signed [PW-1:0]   diff_reg;

    logic                   inside_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [MAG_W-1:0]       mag_out_reg;

    assign re_h = HW'(z_re_reg >>> SPLIT);
    assign im_h = HW'(z_im_reg >>> SPLIT);
    assign re_l = HW'($signed({1'b0, z_re_reg[SPLIT-1:0]}));
    assign im_l = HW'($signed({1'b0, z_im_reg[SPLIT-1:0]}));

    always_ff @(posedge clk)
    begin
        if (cmd.pp_en)
        begin
            rr_hh_reg <= re_h * re_h;
            rr_hl_reg <= re_h * re_l;
            rr_ll_reg <= re_l * re_l;
            ii_hh_reg <= im_h * im_h;
            ii_hl_reg <= im_h * im_l;
            ii_ll_reg <= im_l * im_l;
            ri_hh_reg <= re_h * im_h;
            ri_hl_reg <= re_h * im_l;
            ri_lh_reg <= re_l * im_h;
            ri_ll_reg <= re_l * im_l;
        end
    end

    // 2*h*l term of a square lands at SPLIT+1
    assign re2_next  = (PW'(rr_hh_reg) <<< (2 * SPLIT)) + (PW'(rr_hl_reg) <<< (SPLIT + 1))
                     + PW'(rr_ll_reg);
    assign im2_next  = (PW'(ii_hh_reg) <<< (2 * SPLIT)) + (PW'(ii_hl_reg) <<< (SPLIT + 1))
                     + PW'(ii_ll_reg);
    assign reim_next = (PW'(ri_hh_reg) <<< (2 * SPLIT))
                     + ((PW'(ri_hl_reg) + PW'(ri_lh_reg)) <<< SPLIT) + PW'(ri_ll_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            re2_reg  <= re2_next;
            im2_reg  <= im2_next;
            reim_reg <= reim_next;
        end
        if (cmd.mag_en)
        begin
            mag_reg  <= MW'($unsigned(re2_reg)) + MW'($unsigned(im2_reg));
            diff_reg <= re2_reg - im2_reg;
        end
    end

    assign z_re_next = ZW'(diff_reg >>> FRAC_BITS) + ZW'(c_re_reg);
    assign z_im_next = ZW'(reim_reg >>> (FRAC_BITS - 1)) + ZW'(c_im_reg);
    assign cnt_next  = cnt_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_re_reg <= ZW'(start_re);
            z_im_reg <= ZW'(start_im);
            c_re_reg <= c_re;
            c_im_reg <= c_im;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.upd)
            begin
                z_re_reg <= z_re_next;
                z_im_reg <= z_im_next;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign status.mag_ok = (mag_reg <= MAG_LIMIT);
    assign status.cnt_ok = (cnt_reg <= CNT_W'(max_iter));

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            inside_reg <= !status.cnt_ok;
            iter_reg   <= (cnt_reg > CNT_SAT) ? ITER_W'(CNT_SAT) : cnt_reg[ITER_W-1:0];
            if (!status.cnt_ok)
            begin
                mag_out_reg <= '0;
            end
            else if (|mag_reg[MW-1:MAG_SHIFT+MAG_W])
            begin
                mag_out_reg <= '1;
            end
            else
            begin
                mag_out_reg <= mag_reg[MAG_SHIFT+MAG_W-1:MAG_SHIFT];
            end
        end
    end

    assign inside_res   = inside_reg;
    assign iter_count   = iter_reg;
    assign final_mag_sq = mag_out_reg;

endmodule

// ===== src/meiu_ctrl.sv =====
`include "mandelbrot_escape_iteration_unit_assert.svh"

module meiu_ctrl
    import meiu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PP   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = ST_PP;
                end
            end
            ST_PP:
            begin
                cmd.pp_en  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag_en = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (first_reg)
                begin
                    cmd.upd    = 1'b1;
                    first_next = 1'b0;
                    state_next = ST_PP;
                end
                else if (status.mag_ok && status.cnt_ok)
                begin
                    cmd.upd     = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_PP;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MEIU_ASSERT_SAME(a_first_unchecked, (state_reg == ST_UPD) && first_reg, cmd.upd && !cmd.cnt_inc, "first squaring must update without counting")
    `MEIU_ASSERT_NEXT(a_load_starts, in_valid && in_ready, (state_reg == ST_PP) && first_reg, "accepted request must start with the first squaring")
    `MEIU_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result register overwritten while pending")
    `MEIU_ASSERT_SAME(a_inc_bounded, cmd.cnt_inc, status.mag_ok && status.cnt_ok, "count advanced after escape or limit")

endmodule

// ===== src/mandelbrot_escape_iteration_unit.sv =====
// channel     dir  handshake                   payload
// s_axis      in   s_axis_tvalid/s_axis_tready  start_re, start_im, c_re, c_im
// m_axis      out  m_axis_tvalid/m_axis_tready  iter_count, final_mag_sq; tuser inside_res
// apb         in   psel/penable/pwrite/pready   max_iterations at 0x0
//
// Each iteration walks partial products, product sums, magnitude, update
// through the single squaring datapath.
// s_axis_tready is high only while no request is in flight; a finished result
// waits in the output register and the next request may already be accepted.
// rst_n is asynchronous, active low; max_iterations resets to 255.
module mandelbrot_escape_iteration_unit
    import meiu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [127:0]      s_axis_tdata,   // start_re, start_im, c_re, c_im
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // iter_count, final_mag_sq
    output logic [0:0]        m_axis_tuser,   // inside_res
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]        max_iter_reg, max_iter_next;
    logic               wr_en;
    cmd_t               cmd;
    status_t            status;
    logic               inside_res;
    logic [ITER_W-1:0]  iter_count;
    logic [MAG_W-1:0]   final_mag_sq;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_ITER);

    assign max_iter_next = wr_en ? pwdata[15:0] : max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_ITER) ? {16'd0, max_iter_reg} : 32'd0;

    meiu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    meiu_dp u_dp
    (
        .clk          (clk),
        .cmd          (cmd),
        .start_re     ($signed(s_axis_tdata[31:0])),
        .start_im     ($signed(s_axis_tdata[63:32])),
        .c_re         ($signed(s_axis_tdata[95:64])),
        .c_im         ($signed(s_axis_tdata[127:96])),
        .max_iter     (max_iter_reg),
        .status       (status),
        .inside_res   (inside_res),
        .iter_count   (iter_count),
        .final_mag_sq (final_mag_sq)
    );

    assign m_axis_tdata = {final_mag_sq, iter_count};
    assign m_axis_tuser = inside_res;

endmodule
